// File: hdl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared definitions for the circular deque
// Action and status codes, the default depth and the pending-result record.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int WORD_W    = 32;

  // Action codes of an input item; the remaining codes act as look only
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_REAR   = 3'd3;
  localparam logic [2:0] ACT_LOOK       = 3'd4;

  // Status codes of a result item
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

  // Result under construction while the slot read is in flight
  typedef struct packed {
    logic [1:0] status;
    logic       load_front;
    logic       load_rear;
  } pend_t;

endpackage

// File: hdl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue of signed 32-bit words
// Slots sit in a one-port-write, one-port-read synchronous memory; the front
// and rear words are also held in registers so that each item needs at most
// one slot read.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_action and in_push_value while busy is low; the item
//   is taken at that clock edge. Actions: push front, push rear, pop front,
//   pop rear, look (codes above look also act as look).
//   Exactly one result item follows per input item: in the cycle after the
//   accepting edge, out_valid is high for one cycle with out_status,
//   out_popped_value, out_front_value, out_rear_value and out_is_empty.
//   The receiver cannot stall; the result is gone after that cycle.
// Pacing:
//   busy is high during the result cycle, so no new item is taken until the
//   result has gone out. The registered read port of the slot memory sets
//   this, since it supplies the new end word after a pop.
// Reset:
//   rst_n (synchronous, active low) empties the deque: both indices go to
//   slot 0 and no result is pending. Slot contents are not cleared; only
//   occupied slots are ever read.
// ----------------------------------------------------------------------------
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_popped_value,
  output logic signed [31:0] out_front_value,
  output logic signed [31:0] out_rear_value,
  output logic               out_is_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  // Control state
  logic          state_r,     state_nxt;
  logic [AW-1:0] front_idx_r, front_idx_nxt;
  logic [AW-1:0] rear_idx_r,  rear_idx_nxt;
  logic          empty_r,     empty_nxt;

  // Payload state
  cdq_pkg::word_t front_word_r, front_word_nxt;
  cdq_pkg::word_t rear_word_r,  rear_word_nxt;
  cdq_pkg::word_t popped_r,     popped_nxt;
  cdq_pkg::pend_t pend_r,       pend_nxt;

  // Slot memory
  cdq_pkg::word_t slots_mem [DEPTH];
  cdq_pkg::word_t rd_data_r;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;

  logic          accept;
  logic          full;
  logic [AW-1:0] front_next, front_prev, rear_next, rear_prev;

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] i);
    step_up = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] i);
    step_down = (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  assign busy   = (state_r == S_RESP);
  assign accept = start && !busy;

  assign front_next = step_up(front_idx_r);
  assign front_prev = step_down(front_idx_r);
  assign rear_next  = step_up(rear_idx_r);
  assign rear_prev  = step_down(rear_idx_r);
  assign full       = !empty_r && (rear_next == front_idx_r);

  // Decode the item, move the pointers, touch at most one slot
  always_comb begin
    state_nxt      = state_r;
    front_idx_nxt  = front_idx_r;
    rear_idx_nxt   = rear_idx_r;
    empty_nxt      = empty_r;
    front_word_nxt = front_word_r;
    rear_word_nxt  = rear_word_r;
    popped_nxt     = popped_r;
    pend_nxt       = pend_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;

    if (state_r == S_RESP) begin
      // Retire the result and take the new end word from memory
      state_nxt = S_IDLE;
      if (pend_r.load_front) begin
        front_word_nxt = rd_data_r;
      end
      if (pend_r.load_rear) begin
        rear_word_nxt = rd_data_r;
      end
    end else if (accept) begin
      state_nxt           = S_RESP;
      popped_nxt          = '0;
      pend_nxt.status     = cdq_pkg::ST_DONE;
      pend_nxt.load_front = 1'b0;
      pend_nxt.load_rear  = 1'b0;
      unique case (in_action) inside
        cdq_pkg::ACT_PUSH_FRONT, cdq_pkg::ACT_PUSH_REAR: begin
          if (full) begin
            pend_nxt.status = cdq_pkg::ST_OVERFLOW;
          end else if (empty_r) begin
            // First word lands in slot 0 and is both ends
            front_idx_nxt  = '0;
            rear_idx_nxt   = '0;
            empty_nxt      = 1'b0;
            wr_en          = 1'b1;
            wr_addr        = '0;
            front_word_nxt = in_push_value;
            rear_word_nxt  = in_push_value;
          end else if (in_action == cdq_pkg::ACT_PUSH_FRONT) begin
            front_idx_nxt  = front_prev;
            wr_en          = 1'b1;
            wr_addr        = front_prev;
            front_word_nxt = in_push_value;
          end else begin
            rear_idx_nxt  = rear_next;
            wr_en         = 1'b1;
            wr_addr       = rear_next;
            rear_word_nxt = in_push_value;
          end
        end
        cdq_pkg::ACT_POP_FRONT, cdq_pkg::ACT_POP_REAR: begin
          if (empty_r) begin
            pend_nxt.status = cdq_pkg::ST_EMPTY;
          end else begin
            popped_nxt = (in_action == cdq_pkg::ACT_POP_FRONT) ? front_word_r
                                                               : rear_word_r;
            if (front_idx_r == rear_idx_r) begin
              // Last word gone: return both ends to slot 0
              empty_nxt     = 1'b1;
              front_idx_nxt = '0;
              rear_idx_nxt  = '0;
            end else if (in_action == cdq_pkg::ACT_POP_FRONT) begin
              front_idx_nxt       = front_next;
              rd_en               = 1'b1;
              rd_addr             = front_next;
              pend_nxt.load_front = 1'b1;
            end else begin
              rear_idx_nxt       = rear_prev;
              rd_en              = 1'b1;
              rd_addr            = rear_prev;
              pend_nxt.load_rear = 1'b1;
            end
          end
        end
        default: begin
          // Look only: the deque stays as it is
        end
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_idx_r <= '0;
      rear_idx_r  <= '0;
      empty_r     <= 1'b1;
      pend_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      front_idx_r <= front_idx_nxt;
      rear_idx_r  <= rear_idx_nxt;
      empty_r     <= empty_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Hold end words and the popped word
  always_ff @(posedge clk) begin
    front_word_r <= front_word_nxt;
    rear_word_r  <= rear_word_nxt;
    popped_r     <= popped_nxt;
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_mem[wr_addr] <= in_push_value;
    end
    if (rd_en) begin
      rd_data_r <= slots_mem[rd_addr];
    end
  end

  // Drive the result item during the response cycle
  assign out_valid        = (state_r == S_RESP);
  assign out_status       = pend_r.status;
  assign out_popped_value = popped_r;
  assign out_is_empty     = empty_r;
  assign out_front_value  = empty_r ? '0 : (pend_r.load_front ? rd_data_r : front_word_r);
  assign out_rear_value   = empty_r ? '0 : (pend_r.load_rear ? rd_data_r : rear_word_r);

  // Each accepted item yields its result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result did not follow an accepted item");

  // Results are single-cycle strobes
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // An empty deque keeps both ends at slot 0
  a_empty_home: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (front_idx_r == '0) && (rear_idx_r == '0))
    else $error("empty deque with ends away from slot 0");

  // At most one end word is reloaded per item
  a_one_reload: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r.load_front && pend_r.load_rear))
    else $error("both end words marked for reload");

  // Overflow never reports an empty deque
  a_overflow_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == cdq_pkg::ST_OVERFLOW)) |-> !out_is_empty)
    else $error("overflow reported on an empty deque");

endmodule

// File: tb/cdq_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cdq_scoreboard_pkg: expected-result tracking for the circular deque
// Keeps a private copy of the deque (slots, end indices, empty flag), works out
// the result of every accepted item and compares each result item against
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
package cdq_scoreboard_pkg;

  localparam int SLOTS       = cdq_pkg::DEPTH_DEF;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [1:0]     status;
    cdq_pkg::word_t popped;
    cdq_pkg::word_t front;
    cdq_pkg::word_t rear;
    logic           is_empty;
  } deque_result_t;

  class deque_scoreboard;
    cdq_pkg::word_t  slots [SLOTS];
    int unsigned     front_idx;
    int unsigned     rear_idx;
    bit              empty;
    deque_result_t   expected_q [$];
    int unsigned     failures;

    function new();
      foreach (slots[i]) slots[i] = '0;
      front_idx = 0;
      rear_idx  = 0;
      empty     = 1'b1;
      failures  = 0;
    endfunction

    function int unsigned next_slot(int unsigned i);
      return (i + 1 >= SLOTS) ? 0 : i + 1;
    endfunction

    function int unsigned prev_slot(int unsigned i);
      return (i == 0) ? SLOTS - 1 : i - 1;
    endfunction

    // Advance the deque copy by one item and return the result it causes
    function deque_result_t apply_action(logic [2:0] action, cdq_pkg::word_t value);
      deque_result_t r;
      bit            full;
      r.status = cdq_pkg::ST_DONE;
      r.popped = '0;
      full = !empty && next_slot(rear_idx) == front_idx;
      case (action)
        cdq_pkg::ACT_PUSH_FRONT, cdq_pkg::ACT_PUSH_REAR: begin
          if (full) begin
            r.status = cdq_pkg::ST_OVERFLOW;
          end else if (empty) begin
            // first word always lands in slot 0, whichever end is pushed
            front_idx = 0;
            rear_idx  = 0;
            slots[0]  = value;
            empty     = 1'b0;
          end else if (action == cdq_pkg::ACT_PUSH_FRONT) begin
            front_idx = prev_slot(front_idx);
            slots[front_idx] = value;
          end else begin
            rear_idx = next_slot(rear_idx);
            slots[rear_idx] = value;
          end
        end
        cdq_pkg::ACT_POP_FRONT, cdq_pkg::ACT_POP_REAR: begin
          if (empty) begin
            r.status = cdq_pkg::ST_EMPTY;
          end else begin
            r.popped = (action == cdq_pkg::ACT_POP_FRONT) ? slots[front_idx]
                                                          : slots[rear_idx];
            if (front_idx == rear_idx) begin
              // last word gone: both ends return to slot 0
              empty     = 1'b1;
              front_idx = 0;
              rear_idx  = 0;
            end else if (action == cdq_pkg::ACT_POP_FRONT) begin
              front_idx = next_slot(front_idx);
            end else begin
              rear_idx = prev_slot(rear_idx);
            end
          end
        end
        default: ;  // look only, unused codes included
      endcase
      r.front    = empty ? '0 : slots[front_idx];
      r.rear     = empty ? '0 : slots[rear_idx];
      r.is_empty = empty;
      return r;
    endfunction

    // Record an accepted input item
    function void note_item(logic [2:0] action, cdq_pkg::word_t value);
      expected_q.push_back(apply_action(action, value));
    endfunction

    // Compare one result item with the oldest prediction
    function void check_result(deque_result_t got);
      deque_result_t exp;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("[%0t] unexpected result item: status=%0d popped=%0d", $time,
                   got.status, $signed(got.popped));
        return;
      end
      exp = expected_q.pop_front();
      if (got !== exp) begin
        failures++;
        if (failures <= REPORT_MAX) begin
          $display("[%0t] mismatch: expected status=%0d popped=%0d front=%0d rear=%0d empty=%0b",
                   $time, exp.status, $signed(exp.popped), $signed(exp.front),
                   $signed(exp.rear), exp.is_empty);
          $display("[%0t]           actual   status=%0d popped=%0d front=%0d rear=%0d empty=%0b",
                   $time, got.status, $signed(got.popped), $signed(got.front),
                   $signed(got.rear), got.is_empty);
        end
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

endpackage

// File: tb/circular_deque_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_test: self-checking bench for the circular deque
// Runs a directed pass over empty, full, wrap and unused-code cases, then
// about 1900 random items in push-heavy, pop-heavy and balanced phases with
// random gaps; every result item is checked against a scoreboard prediction.
// ----------------------------------------------------------------------------
module circular_deque_test;

  localparam int RANDOM_ITEMS = 1900;
  localparam int PHASE_LEN    = 40;
  localparam int TAIL_CYCLES  = 4;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               start         = 1'b0;
  logic [2:0]         in_action     = cdq_pkg::ACT_LOOK;
  logic signed [31:0] in_push_value = '0;
  logic               busy;
  logic               out_valid;
  logic [1:0]         out_status;
  logic signed [31:0] out_popped_value;
  logic signed [31:0] out_front_value;
  logic signed [31:0] out_rear_value;
  logic               out_is_empty;

  cdq_scoreboard_pkg::deque_scoreboard sb = new();

  circular_deque DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_front_value  (out_front_value),
    .out_rear_value   (out_rear_value),
    .out_is_empty     (out_is_empty)
  );

  always #10 clk = ~clk;

  // Watch both channels; check results before noting a new item
  always @(posedge clk) begin : watch
    cdq_scoreboard_pkg::deque_result_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.status   = out_status;
        got.popped   = out_popped_value;
        got.front    = out_front_value;
        got.rear     = out_rear_value;
        got.is_empty = out_is_empty;
        sb.check_result(got);
      end
      if (start && !busy)
        sb.note_item(in_action, in_push_value);
    end
  end

  // Offer one item, after a random gap unless no_gap is set, and hold it until taken
  task automatic send_item(input logic [2:0] action, input cdq_pkg::word_t value,
                           input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_action     <= action;
    in_push_value <= value;
    do @(posedge clk); while (busy);
  endtask

  // Hold off the sender until every predicted result has arrived
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int              push_pct;
    bit              no_gap;
    int              pick;
    logic [2:0]      action;
    cdq_pkg::word_t  value;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty deque, single word, extremes, full deque, unused codes
    send_item(cdq_pkg::ACT_LOOK,       32'h0000_1234, 1'b0);
    send_item(cdq_pkg::ACT_POP_FRONT,  32'h0,         1'b0);
    send_item(cdq_pkg::ACT_POP_REAR,   32'hFFFF_FFFF, 1'b0);
    send_item(cdq_pkg::ACT_PUSH_REAR,  32'h5A5A_A5A5, 1'b0);
    send_item(cdq_pkg::ACT_POP_REAR,   32'h0,         1'b0);
    send_item(cdq_pkg::ACT_PUSH_FRONT, 32'h8000_0000, 1'b0);
    send_item(cdq_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1);
    send_item(cdq_pkg::ACT_PUSH_REAR,  32'hFFFF_FFFF, 1'b1);
    send_item(cdq_pkg::ACT_PUSH_REAR,  32'h0000_0000, 1'b0);
    send_item(cdq_pkg::ACT_PUSH_FRONT, 32'h0000_0001, 1'b0);
    send_item(cdq_pkg::ACT_PUSH_REAR,  32'hAAAA_AAAA, 1'b1);
    send_item(cdq_pkg::ACT_PUSH_FRONT, 32'h5555_5555, 1'b0);
    send_item(cdq_pkg::ACT_PUSH_REAR,  32'hFFFF_FFFE, 1'b0);
    send_item(cdq_pkg::ACT_PUSH_FRONT, 32'h1111_1111, 1'b0);
    send_item(cdq_pkg::ACT_PUSH_REAR,  32'h2222_2222, 1'b1);
    send_item(3'd5,                    32'h0,         1'b0);
    send_item(3'd6,                    32'hFFFF_FFFF, 1'b0);
    send_item(3'd7,                    32'h8000_0000, 1'b0);
    repeat (4) send_item(cdq_pkg::ACT_POP_FRONT, 32'h0, 1'b0);
    repeat (4) send_item(cdq_pkg::ACT_POP_REAR,  32'h0, 1'b1);
    send_item(cdq_pkg::ACT_POP_FRONT, 32'h0, 1'b0);
    drain_results();

    // Random: phases biased toward filling, emptying or mixing
    push_pct = 50;
    no_gap   = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
        no_gap = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_ITEMS / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 6)
        action = 3'($urandom_range(4, 7));
      else if (pick < 6 + (94 * push_pct) / 100)
        action = 3'($urandom_range(0, 1));
      else
        action = 3'($urandom_range(2, 3));
      case ($urandom_range(0, 9))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = 32'hFFFF_FFFF;
        3:       value = 32'h0000_0000;
        default: value = $urandom;
      endcase
      send_item(action, value, no_gap);
    end

    // Let the last result arrive, then settle
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
